FILE: hw/rtl/packet_protocol_statistics_defines.svh
// Assertion macros shared by the packet protocol statistics RTL.
`ifndef PACKET_PROTOCOL_STATISTICS_DEFINES_SVH
`define PACKET_PROTOCOL_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pps: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pps: next-cycle check failed");

`endif

FILE: hw/rtl/pps_pkg.sv
// Types, constants and the port classifier for the packet protocol statistics block.
package pps_pkg;

  localparam int unsigned TagWidth     = 16;
  localparam int unsigned LenWidth     = 16;
  localparam int unsigned PortWidth    = 16;
  localparam int unsigned IndexWidth   = 6;
  localparam int unsigned ValueWidth   = 48;
  localparam int unsigned NumCounters  = 31;
  localparam int unsigned NumSums      = 3;
  localparam int unsigned GroupSize    = 12;
  localparam int unsigned CntSelWidth  = $clog2(NumCounters);
  localparam int unsigned SumSelWidth  = $clog2(NumSums);
  localparam int unsigned GrpSelWidth  = $clog2(GroupSize);

  // Packet counter map.
  localparam int unsigned CTotal   = 0;
  localparam int unsigned CVlan    = 1;
  localparam int unsigned CQinq    = 2;
  localparam int unsigned CArp     = 3;
  localparam int unsigned CIpv4    = 4;
  localparam int unsigned CIpv6    = 5;
  localparam int unsigned CL3Other = 6;
  localparam int unsigned V4Base   = 7;
  localparam int unsigned V6Base   = V4Base + GroupSize;

  // Offsets inside one IP group.
  localparam logic [GrpSelWidth-1:0] GTcp     = GrpSelWidth'(0);
  localparam logic [GrpSelWidth-1:0] GUdp     = GrpSelWidth'(1);
  localparam logic [GrpSelWidth-1:0] GIcmp    = GrpSelWidth'(2);
  localparam logic [GrpSelWidth-1:0] GL4Other = GrpSelWidth'(3);
  localparam logic [GrpSelWidth-1:0] GDns     = GrpSelWidth'(4);
  localparam logic [GrpSelWidth-1:0] GSmtp    = GrpSelWidth'(5);
  localparam logic [GrpSelWidth-1:0] GHttp    = GrpSelWidth'(6);
  localparam logic [GrpSelWidth-1:0] GPop3    = GrpSelWidth'(7);
  localparam logic [GrpSelWidth-1:0] GImap    = GrpSelWidth'(8);
  localparam logic [GrpSelWidth-1:0] GSmb     = GrpSelWidth'(9);
  localparam logic [GrpSelWidth-1:0] GFtp     = GrpSelWidth'(10);
  localparam logic [GrpSelWidth-1:0] GL7Other = GrpSelWidth'(11);

  // Byte sum map.
  localparam int unsigned SAll = 0;
  localparam int unsigned STcp = 1;
  localparam int unsigned SUdp = 2;

  // Flag bit positions.
  localparam int unsigned FfLen  = 0;
  localparam int unsigned FfEth  = 1;
  localparam int unsigned TfVlan = 0;
  localparam int unsigned TfQinq = 1;
  localparam int unsigned L3Arp  = 0;
  localparam int unsigned L3Ipv4 = 1;
  localparam int unsigned L3Ipv6 = 2;
  localparam int unsigned L4Tcp  = 0;
  localparam int unsigned L4Udp  = 1;
  localparam int unsigned L4Icmp4 = 2;
  localparam int unsigned L4Icmp6 = 3;

  // Well-known application ports.
  localparam logic [PortWidth-1:0] PortDns    = 16'd53;
  localparam logic [PortWidth-1:0] PortSmtp   = 16'd25;
  localparam logic [PortWidth-1:0] PortHttp   = 16'd80;
  localparam logic [PortWidth-1:0] PortHttpAl = 16'd8080;
  localparam logic [PortWidth-1:0] PortPop3   = 16'd110;
  localparam logic [PortWidth-1:0] PortImap   = 16'd143;
  localparam logic [PortWidth-1:0] PortNetb   = 16'd139;
  localparam logic [PortWidth-1:0] PortSmb    = 16'd445;
  localparam logic [PortWidth-1:0] PortFtpDat = 16'd20;
  localparam logic [PortWidth-1:0] PortFtpCtl = 16'd21;

  // Register reset values.
  localparam logic [TagWidth-1:0] Ipv4TagReset = 16'h0800;
  localparam logic [TagWidth-1:0] Ipv6TagReset = 16'h86DD;
  localparam logic [TagWidth-1:0] ArpTagReset  = 16'h0806;
  localparam logic [TagWidth-1:0] VlanTagReset = 16'h8100;

  typedef enum logic {
    CmdCount = 1'b0,
    CmdRead  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegIpv4Tag = 2'd0,
    RegIpv6Tag = 2'd1,
    RegArpTag  = 2'd2,
    RegVlanTag = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TagWidth-1:0] ipv4_tag;
    logic [TagWidth-1:0] ipv6_tag;
    logic [TagWidth-1:0] arp_tag;
    logic [TagWidth-1:0] vlan_tag;
  } cfg_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [1:0]            frame_flags;
    logic [LenWidth-1:0]   pkt_len;
    logic [TagWidth-1:0]   ethertype;
    logic [1:0]            tag_flags;
    logic [TagWidth-1:0]   vlan_inner_type;
    logic [TagWidth-1:0]   qinq_inner_type;
    logic [2:0]            l3_flags;
    logic [3:0]            l4_flags;
    logic [PortWidth-1:0]  src_port;
    logic [PortWidth-1:0]  dst_port;
    logic [IndexWidth-1:0] counter_index;
  } item_t;

  typedef struct packed {
    logic [NumCounters-1:0] bump;
    logic [NumSums-1:0]     add;
    logic [TagWidth-1:0]    tag;
  } upd_t;

  function automatic logic [GrpSelWidth-1:0] port_class(input logic [PortWidth-1:0] s,
                                                        input logic [PortWidth-1:0] d);
    logic [GrpSelWidth-1:0] cls;
    if (s == PortDns || d == PortDns) begin
      cls = GDns;
    end else if (d == PortSmtp) begin
      cls = GSmtp;
    end else if (s == PortHttp || d == PortHttp || s == PortHttpAl || d == PortHttpAl) begin
      cls = GHttp;
    end else if (d == PortPop3) begin
      cls = GPop3;
    end else if (s == PortImap || d == PortImap) begin
      cls = GImap;
    end else if (s == PortNetb || d == PortNetb || s == PortSmb || d == PortSmb) begin
      cls = GSmb;
    end else if (s == PortFtpDat || d == PortFtpDat || s == PortFtpCtl || d == PortFtpCtl) begin
      cls = GFtp;
    end else begin
      cls = GL7Other;
    end
    return cls;
  endfunction

endpackage

FILE: hw/rtl/pps_classify.sv
// Classifier: decides which counters and byte sums one packet word updates.
module pps_classify (
  input  pps_pkg::item_t                 item_i,
  input  logic [pps_pkg::TagWidth-1:0]   tag_i,
  input  pps_pkg::cfg_t                  cfg_i,
  output pps_pkg::upd_t                  upd_o
);
  import pps_pkg::*;

  logic [TagWidth-1:0]  tag_eth;
  logic [TagWidth-1:0]  tag_fin;
  logic                 is_v4;
  logic                 is_v6;
  logic                 has_tcp;
  logic                 has_udp;
  logic [GroupSize-1:0] grp;
  logic [GrpSelWidth-1:0] pcls;

  assign tag_eth = item_i.frame_flags[FfEth] ? item_i.ethertype : tag_i;
  assign has_tcp = item_i.l4_flags[L4Tcp];
  assign has_udp = item_i.l4_flags[L4Udp];
  assign pcls    = port_class(item_i.src_port, item_i.dst_port);

  always_comb begin
    upd_o = '0;
    grp   = '0;
    tag_fin = tag_eth;

    upd_o.bump[CTotal] = item_i.frame_flags[FfEth];

    // A later QinQ header overrides the VLAN inner type.
    if (tag_eth == cfg_i.vlan_tag) begin
      if (item_i.tag_flags[TfVlan]) begin
        upd_o.bump[CVlan] = 1'b1;
        tag_fin = item_i.vlan_inner_type;
      end
      if (item_i.tag_flags[TfQinq]) begin
        upd_o.bump[CQinq] = 1'b1;
        tag_fin = item_i.qinq_inner_type;
      end
    end

    is_v4 = (tag_fin == cfg_i.ipv4_tag);
    is_v6 = !is_v4 && (tag_fin == cfg_i.ipv6_tag);

    if (is_v4 && item_i.l3_flags[L3Ipv4]) begin
      upd_o.bump[CIpv4] = 1'b1;
    end else if (tag_fin == cfg_i.ipv6_tag && item_i.l3_flags[L3Ipv6]) begin
      upd_o.bump[CIpv6] = 1'b1;
    end else if (tag_fin == cfg_i.arp_tag && item_i.l3_flags[L3Arp]) begin
      upd_o.bump[CArp] = 1'b1;
    end else begin
      upd_o.bump[CL3Other] = 1'b1;
    end

    if (has_tcp) begin
      grp[GTcp] = 1'b1;
      grp[pcls] = 1'b1;
    end else if (has_udp) begin
      grp[GUdp] = 1'b1;
      grp[pcls] = 1'b1;
    end else if (item_i.l4_flags[L4Icmp4] || item_i.l4_flags[L4Icmp6]) begin
      grp[GIcmp] = 1'b1;
    end else begin
      grp[GL4Other] = 1'b1;
    end

    if (is_v4) begin
      upd_o.bump[V4Base +: GroupSize] = grp;
    end else if (is_v6) begin
      upd_o.bump[V6Base +: GroupSize] = grp;
    end

    upd_o.add[SAll] = item_i.frame_flags[FfLen];
    upd_o.add[STcp] = item_i.frame_flags[FfLen] && has_tcp;
    upd_o.add[SUdp] = item_i.frame_flags[FfLen] && !has_tcp && has_udp;

    upd_o.tag = tag_fin;
  end

endmodule

FILE: hw/rtl/packet_protocol_statistics.sv
// Top level of the packet protocol statistics block: word register, counters, read port.
// Order: a read word is registered in the input word register at acceptance and its
// result then goes into the output register; count words update the counters from there.
// Throughput: one word per cycle; only a read word waiting on a stalled output holds input.
// Reset clears all counters, the protocol tag and the valid flags, and loads the four
// ethertype registers with their default codes.
module packet_protocol_statistics #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned SUM_WIDTH   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [pps_pkg::TagWidth-1:0]        cfg_data_i,
  // Input word channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [1:0]                          frame_flags_i,
  input  logic [pps_pkg::LenWidth-1:0]        pkt_len_i,
  input  logic [pps_pkg::TagWidth-1:0]        ethertype_i,
  input  logic [1:0]                          tag_flags_i,
  input  logic [pps_pkg::TagWidth-1:0]        vlan_inner_type_i,
  input  logic [pps_pkg::TagWidth-1:0]        qinq_inner_type_i,
  input  logic [2:0]                          l3_flags_i,
  input  logic [3:0]                          l4_flags_i,
  input  logic [pps_pkg::PortWidth-1:0]       src_port_i,
  input  logic [pps_pkg::PortWidth-1:0]       dst_port_i,
  input  logic [pps_pkg::IndexWidth-1:0]      counter_index_i,
  // Result word channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pps_pkg::ValueWidth-1:0]      counter_value_o
);
  import pps_pkg::*;

  `include "packet_protocol_statistics_defines.svh"

  // The configuration registers are plain flops and take a write in any cycle.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ipv4_tag <= Ipv4TagReset;
      cfg_q.ipv6_tag <= Ipv6TagReset;
      cfg_q.arp_tag  <= ArpTagReset;
      cfg_q.vlan_tag <= VlanTagReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegIpv4Tag: cfg_q.ipv4_tag <= cfg_data_i;
        RegIpv6Tag: cfg_q.ipv6_tag <= cfg_data_i;
        RegArpTag:  cfg_q.arp_tag  <= cfg_data_i;
        RegVlanTag: cfg_q.vlan_tag <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input word register. A count word always leaves it in the next cycle; a read
  // word leaves only when the output register is free or being emptied.
  item_t item_in;
  item_t s1_q;
  logic  s1_valid_q;
  logic  s1_adv;
  logic  s1_cnt_adv;
  logic  s1_rd_adv;

  assign item_in.cmd             = cmd_e'(cmd_i);
  assign item_in.frame_flags     = frame_flags_i;
  assign item_in.pkt_len         = pkt_len_i;
  assign item_in.ethertype       = ethertype_i;
  assign item_in.tag_flags       = tag_flags_i;
  assign item_in.vlan_inner_type = vlan_inner_type_i;
  assign item_in.qinq_inner_type = qinq_inner_type_i;
  assign item_in.l3_flags        = l3_flags_i;
  assign item_in.l4_flags        = l4_flags_i;
  assign item_in.src_port        = src_port_i;
  assign item_in.dst_port        = dst_port_i;
  assign item_in.counter_index   = counter_index_i;

  logic out_valid_q;

  assign in_stall_o = s1_valid_q && (s1_q.cmd == CmdRead) && out_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !in_stall_o;
  assign s1_cnt_adv = s1_adv && (s1_q.cmd == CmdCount);
  assign s1_rd_adv  = s1_adv && (s1_q.cmd == CmdRead);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_q <= item_in;
    end
  end

  // Classification of the registered word against the running protocol tag.
  logic [TagWidth-1:0] tag_q;
  upd_t                upd;

  pps_classify u_classify (
    .item_i (s1_q),
    .tag_i  (tag_q),
    .cfg_i  (cfg_q),
    .upd_o  (upd)
  );

  // The tag carries over to the next word when no Ethernet header refreshes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (s1_cnt_adv) begin
      tag_q <= upd.tag;
    end
  end

  // Packet counters and byte sums, each with its own incrementer; they wrap.
  logic [COUNT_WIDTH-1:0] cnt_q [NumCounters];
  logic [SUM_WIDTH-1:0]   sum_q [NumSums];

  for (genvar gi = 0; gi < NumCounters; gi++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[gi] <= '0;
      end else if (s1_cnt_adv && upd.bump[gi]) begin
        cnt_q[gi] <= cnt_q[gi] + COUNT_WIDTH'(1);
      end
    end
  end

  for (genvar gs = 0; gs < NumSums; gs++) begin : g_sum
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[gs] <= '0;
      end else if (s1_cnt_adv && upd.add[gs]) begin
        sum_q[gs] <= sum_q[gs] + SUM_WIDTH'(s1_q.pkt_len);
      end
    end
  end

  // Read selection. Counters are widened to 64 bits and the low result bits are
  // given, so narrower counters read zero-extended and wider ones truncated.
  logic [63:0]            rd_wide;
  logic [CntSelWidth-1:0] cnt_sel;
  logic [SumSelWidth-1:0] sum_sel;

  assign cnt_sel = s1_q.counter_index[CntSelWidth-1:0];
  assign sum_sel = SumSelWidth'(s1_q.counter_index - IndexWidth'(NumCounters));

  always_comb begin
    if (s1_q.counter_index < IndexWidth'(NumCounters)) begin
      rd_wide = 64'(cnt_q[cnt_sel]);
    end else if (s1_q.counter_index < IndexWidth'(NumCounters + NumSums)) begin
      rd_wide = 64'(sum_q[sum_sel]);
    end else begin
      rd_wide = '0;
    end
  end

  // Output register: filled by a read word, held while the receiver stalls.
  logic [ValueWidth-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_rd_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rd_adv) begin
      value_q <= rd_wide[ValueWidth-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign counter_value_o = value_q;

  // Only a read word blocked by a full, stalled output register may hold the input.
  `PPS_ASSERT_NOW(a_stall_only_on_read, clk_i, rst_ni, in_stall_o,
                  s1_valid_q && s1_q.cmd == CmdRead && out_valid_q)
  // A read word leaving the input register always produces a result word.
  `PPS_ASSERT_NEXT(a_read_gives_result, clk_i, rst_ni, s1_rd_adv, out_valid_q)
  // Every count word lands in exactly one layer 3 class.
  `PPS_ASSERT_NOW(a_one_l3_class, clk_i, rst_ni, s1_cnt_adv,
                  $countones(upd.bump[CL3Other:CArp]) == 1)

endmodule
